>>> hw/rtl/hex_line_draw_assert.svh
// Assertion macros used by the hex line draw datapath.
`ifndef HEX_LINE_DRAW_ASSERT_SVH
`define HEX_LINE_DRAW_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define HLD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HLD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hld_pkg.sv
`default_nettype none

package hld_pkg;

   localparam int COORD_W      = 8;
   localparam int STEP_W       = 6;
   localparam int HLD_MAX_DIST = 63;

   // one request beat: line start and end in axial coordinates
   typedef struct packed {
      logic signed [COORD_W-1:0] start_q;
      logic signed [COORD_W-1:0] start_r;
      logic signed [COORD_W-1:0] target_q;
      logic signed [COORD_W-1:0] target_r;
   } hld_req_type;

   // one response beat: a cell of the line
   typedef struct packed {
      logic signed [COORD_W-1:0] cell_q;
      logic signed [COORD_W-1:0] cell_r;
      logic [STEP_W-1:0]         step_index;
      logic                      last_cell;
      logic                      too_far;
   } hld_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic init;
      logic emit;
   } hld_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } hld_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/hex_line_draw.sv
`default_nettype none

// Hex line draw: walks the cells of the line between two axial hexes.
// Request: drive req_data and raise start; the beat is taken at an edge where
// start is high and busy is low. busy stays high until the last cell of the
// line has been produced.
// Response: each cell shows on rsp_data for one cycle with rsp_valid high;
// the receiver cannot stall, so every beat must be taken when it appears.
// Cells come in order from the start (step 0) to the target (step d), the
// last one marked by last_cell. A distance above MAX_DIST gives one beat with
// too_far and last_cell set and the cell fields zero.
// The request is captured into the end-point registers, the distance state
// computes the hex distance and sets up the walk, then one cell leaves per
// cycle from the stepping datapath through the response register. A new
// request is not taken until the line (or the single too-far beat) has been
// emitted and the controller is back in idle.
// Reset clears the controller and the response strobe; nothing else needs it.
module hex_line_draw
   import hld_pkg::*;
#(
   parameter int MAX_DIST = HLD_MAX_DIST
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hld_req_type req_data,
   output logic        rsp_valid,
   output hld_rsp_type rsp_data
);

   hld_cmd_type    cmd;
   hld_status_type status;

   hld_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   hld_datapath #(
      .MAX_DIST (MAX_DIST)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/hld_datapath.sv
`default_nettype none

`include "hex_line_draw_assert.svh"

module hld_datapath
   import hld_pkg::*;
#(
   parameter int MAX_DIST = HLD_MAX_DIST
) (
   input  logic           clock,
   input  logic           reset,
   input  hld_req_type    req_data,
   input  hld_cmd_type    cmd,
   output hld_status_type status,
   output logic           rsp_valid,
   output hld_rsp_type    rsp_data
);

   localparam int WIDE_W = 10;   // interpolated values, s spans -254 to +256
   localparam int DIST_W = 10;   // full distance, up to 510
   localparam int REM_W  = 6;    // remainder below a distance of at most 63
   localparam int SUM_W  = 11;

   typedef struct packed {
      logic signed [WIDE_W-1:0] value;
      logic [REM_W:0]           err;
   } round_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] quot;
      logic [REM_W-1:0]         rem;
   } frac_type;

   // round quot + rem/den half away from zero, with error scaled by den
   function automatic round_type round_frac(input logic signed [WIDE_W-1:0] quot,
                                            input logic [REM_W-1:0] rem,
                                            input logic [REM_W-1:0] den);
      logic [REM_W:0] twice;
      logic [REM_W:0] dist_x;
      round_type      res;
      twice  = {rem, 1'b0};
      dist_x = {1'b0, den};
      priority if (rem == '0 || twice < dist_x) begin
         res.value = quot;
         res.err   = {1'b0, rem};
      end else if (twice > dist_x || !quot[WIDE_W-1]) begin
         res.value = quot + WIDE_W'(1);
         res.err   = dist_x - {1'b0, rem};
      end else begin
         res.value = quot;
         res.err   = {1'b0, rem};
      end
      return res;
   endfunction

   // move one step along the line: add delta/den to quot + rem/den
   function automatic frac_type advance(input frac_type cur,
                                        input logic signed [WIDE_W-1:0] delta,
                                        input logic [REM_W-1:0] den);
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] dist_x;
      frac_type                res;
      dist_x = $signed({{(SUM_W-REM_W){1'b0}}, den});
      sum    = $signed({{(SUM_W-REM_W){1'b0}}, cur.rem})
             + $signed({delta[WIDE_W-1], delta});
      priority if (sum >= dist_x) begin
         res.quot = cur.quot + WIDE_W'(1);
         res.rem  = REM_W'(sum - dist_x);
      end else if (sum < 0) begin
         res.quot = cur.quot - WIDE_W'(1);
         res.rem  = REM_W'(sum + dist_x);
      end else begin
         res.quot = cur.quot;
         res.rem  = REM_W'(sum);
      end
      return res;
   endfunction

   logic signed [COORD_W-1:0] a_q_ff, a_r_ff, b_q_ff, b_r_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic                      far_ff;
   logic signed [WIDE_W-1:0]  dq_ff, dr_ff, ds_ff;
   frac_type                  fq_ff, fr_ff, fs_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      rsp_valid_ff;
   hld_rsp_type               rsp_ff;

   logic signed [WIDE_W-1:0]  diff_q, diff_r, diff_s;
   logic [WIDE_W-1:0]         abs_q, abs_r, abs_s;
   logic [SUM_W-1:0]          abs_sum;
   logic [DIST_W-1:0]         dist_in;
   logic [REM_W-1:0]          dist_lo;
   round_type                 rnd_q, rnd_r, rnd_s;
   logic signed [WIDE_W-1:0]  cell_q, cell_r;
   logic                      last_in;
   hld_rsp_type               rsp_in;

   // hex distance from the captured end points
   always_comb begin
      diff_q  = WIDE_W'(b_q_ff) - WIDE_W'(a_q_ff);
      diff_r  = WIDE_W'(b_r_ff) - WIDE_W'(a_r_ff);
      diff_s  = -(diff_q + diff_r);
      abs_q   = diff_q[WIDE_W-1] ? WIDE_W'(-diff_q) : WIDE_W'(diff_q);
      abs_r   = diff_r[WIDE_W-1] ? WIDE_W'(-diff_r) : WIDE_W'(diff_r);
      abs_s   = diff_s[WIDE_W-1] ? WIDE_W'(-diff_s) : WIDE_W'(diff_s);
      abs_sum = SUM_W'(abs_q) + SUM_W'(abs_r) + SUM_W'(abs_s);
      dist_in = abs_sum[SUM_W-1:1];
   end

   // round the three components, rebuild the one with the largest error, form the beat
   always_comb begin
      dist_lo = dist_ff[REM_W-1:0];
      rnd_q   = round_frac(fq_ff.quot, fq_ff.rem, dist_lo);
      rnd_r   = round_frac(fr_ff.quot, fr_ff.rem, dist_lo);
      rnd_s   = round_frac(fs_ff.quot, fs_ff.rem, dist_lo);
      cell_q  = rnd_q.value;
      cell_r  = rnd_r.value;
      priority if (rnd_q.err > rnd_r.err && rnd_q.err > rnd_s.err) begin
         cell_q = -rnd_r.value - rnd_s.value;
      end else if (rnd_r.err > rnd_s.err) begin
         cell_r = -rnd_q.value - rnd_s.value;
      end else begin
         cell_q = rnd_q.value;
      end
      last_in = far_ff || ({{(DIST_W-STEP_W){1'b0}}, step_ff} == dist_ff);
      if (far_ff) begin
         rsp_in         = '0;
         rsp_in.too_far = 1'b1;
      end else begin
         rsp_in.cell_q     = cell_q[COORD_W-1:0];
         rsp_in.cell_r     = cell_r[COORD_W-1:0];
         rsp_in.step_index = step_ff;
         rsp_in.too_far    = 1'b0;
      end
      rsp_in.last_cell = 1'b1;
      if (!far_ff) begin
         rsp_in.last_cell = last_in;
      end
   end

   assign status.last = last_in;

   // capture request, set up the walk, step once per emitted beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_q_ff <= req_data.start_q;
         a_r_ff <= req_data.start_r;
         b_q_ff <= req_data.target_q;
         b_r_ff <= req_data.target_r;
      end
      if (cmd.init) begin
         dist_ff    <= dist_in;
         far_ff     <= dist_in > DIST_W'(MAX_DIST);
         dq_ff      <= diff_q;
         dr_ff      <= diff_r;
         ds_ff      <= diff_s;
         fq_ff.quot <= WIDE_W'(a_q_ff);
         fr_ff.quot <= WIDE_W'(a_r_ff);
         fs_ff.quot <= -WIDE_W'(a_q_ff) - WIDE_W'(a_r_ff);
         fq_ff.rem  <= '0;
         fr_ff.rem  <= '0;
         fs_ff.rem  <= '0;
         step_ff    <= '0;
      end else if (cmd.emit) begin
         fq_ff   <= advance(fq_ff, dq_ff, dist_lo);
         fr_ff   <= advance(fr_ff, dr_ff, dist_lo);
         fs_ff   <= advance(fs_ff, ds_ff, dist_lo);
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // result valid, registered from the emit command
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `HLD_ASSERT_NEXT(a_last_beat, cmd.emit && last_in, rsp_valid_ff && rsp_ff.last_cell, "last emit did not mark last beat")
   `HLD_ASSERT_SAME(a_far_zero, rsp_valid_ff && rsp_ff.too_far, rsp_ff.cell_q == '0 && rsp_ff.cell_r == '0 && rsp_ff.last_cell, "too-far beat not zero and last")
   `HLD_ASSERT_NEXT(a_step_seq, rsp_valid_ff && !rsp_ff.last_cell, rsp_valid_ff && rsp_ff.step_index == $past(rsp_ff.step_index) + STEP_W'(1), "step index gap inside a line")
   `HLD_ASSERT_SAME(a_rem_range, cmd.emit && !far_ff && dist_ff != '0, fq_ff.rem < dist_lo && fr_ff.rem < dist_lo && fs_ff.rem < dist_lo, "remainder not below distance")

endmodule

`default_nettype wire

>>> hw/rtl/hld_control.sv
`default_nettype none

module hld_control
   import hld_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  hld_status_type status,
   output hld_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIST,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decode commands
   assign cmd.load = start && (state_ff == ST_IDLE);
   assign cmd.init = (state_ff == ST_DIST);
   assign cmd.emit = (state_ff == ST_EMIT);
   assign busy     = (state_ff != ST_IDLE);

endmodule

`default_nettype wire
